### rtl/core/fqd_pkg.sv
package fqd_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned CountW = 10;
    localparam int unsigned AddrW  = 2;
    localparam int unsigned DataW  = 32;

    localparam logic [ByteW-1:0]  ChAmp   = 8'h26;
    localparam logic [ByteW-1:0]  ChEq    = 8'h3D;
    localparam logic [ByteW-1:0]  ChPct   = 8'h25;
    localparam logic [ByteW-1:0]  ChPlus  = 8'h2B;
    localparam logic [ByteW-1:0]  ChSpace = 8'h20;

    localparam logic [CountW-1:0] CountMax       = 10'h3FF;
    localparam logic [CountW-1:0] MaxLengthReset = 10'd900;

    localparam logic [AddrW-1:0]  RegMaxLength = 2'd0;

    typedef enum logic [2:0] {
        ESC_IDLE = 3'b001,
        ESC_HIGH = 3'b010,
        ESC_LOW  = 3'b100
    } t_esc_state;

    typedef struct packed {
        logic             data_valid;
        logic [ByteW-1:0] out_byte;
        logic             in_name;
        logic             pair_end;
        logic             query_done;
        logic             too_long;
    } t_result;

    function automatic logic [4:0] digit_value(input logic [ByteW-1:0] c);
        digit_value = {1'b0, c[3:0]} + (c[6] ? 5'd9 : 5'd0);
    endfunction

endpackage

### rtl/core/fqd_cfg.sv
module fqd_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fqd_pkg::AddrW-1:0]   paddr,
    input  logic [fqd_pkg::DataW-1:0]   pwdata,
    output logic [fqd_pkg::DataW-1:0]   prdata,
    output logic                        pready,
    output logic [fqd_pkg::CountW-1:0]  o_max_length
);
    import fqd_pkg::*;

    logic [CountW-1:0] r_max_length;
    logic [CountW-1:0] n_max_length;
    logic              wr_hit;

    assign wr_hit = psel & penable & pwrite & (paddr == RegMaxLength);

    always_comb begin
        n_max_length = r_max_length;
        if (wr_hit) begin
            n_max_length = pwdata[CountW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= MaxLengthReset;
        end else begin
            r_max_length <= n_max_length;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == RegMaxLength) begin
            prdata = {{(DataW-CountW){1'b0}}, r_max_length};
        end
    end

    assign pready       = 1'b1;
    assign o_max_length = r_max_length;

endmodule

### rtl/core/fqd_step.sv
module fqd_step (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [fqd_pkg::ByteW-1:0]   i_in_byte,
    input  logic                        i_query_end,
    input  logic [fqd_pkg::CountW-1:0]  i_max_length,
    output logic                        o_push,
    output fqd_pkg::t_result            o_result
);
    import fqd_pkg::*;

    t_esc_state        r_esc,   n_esc;
    logic [3:0]        r_high,  n_high;
    logic              r_name,  n_name;
    logic [CountW-1:0] r_count, n_count;
    logic              r_ovf,   n_ovf;

    logic [CountW:0]   count_inc;
    logic              ovf;
    logic [CountW-1:0] count_sat;
    logic              is_amp;
    logic [ByteW-1:0]  c;
    logic [4:0]        dig;
    logic              dec;
    logic [ByteW-1:0]  ch;
    logic              have;
    logic              pend;
    logic              name_end;

    assign count_inc = {1'b0, r_count} + {{CountW{1'b0}}, 1'b1};
    assign ovf       = r_ovf | (count_inc > {1'b0, i_max_length});
    assign count_sat = count_inc[CountW] ? CountMax : count_inc[CountW-1:0];
    assign is_amp    = (i_in_byte == ChAmp);
    assign c         = (i_in_byte == ChPlus) ? ChSpace : i_in_byte;
    assign dig       = digit_value(c);

    always_comb begin
        n_esc = r_esc;
        n_high = r_high;
        dec = 1'b0;
        ch = c;
        if (is_amp) begin
            n_esc = ESC_IDLE;
            n_high = '0;
        end else begin
            case (r_esc)
                ESC_HIGH: begin
                    n_high = dig[3:0];
                    n_esc = ESC_LOW;
                end
                ESC_LOW: begin
                    ch = {r_high, 4'b0000} | {3'b000, dig};
                    n_esc = ESC_IDLE;
                    n_high = '0;
                    dec = 1'b1;
                end
                default: begin
                    if (c == ChPct) begin
                        n_esc = ESC_HIGH;
                    end else begin
                        dec = 1'b1;
                    end
                end
            endcase
        end
        if (i_query_end) begin
            n_esc  = ESC_IDLE;
            n_high = '0;
        end
    end

    assign name_end = dec & r_name & (ch == ChEq);
    assign have     = dec & ~name_end & ~ovf;
    assign pend     = is_amp & ~ovf;

    always_comb begin
        n_name  = r_name;
        n_count = count_sat;
        n_ovf   = ovf;
        if (is_amp) begin
            n_name = 1'b1;
        end else if (name_end) begin
            n_name = 1'b0;
        end
        if (i_query_end) begin
            n_name  = 1'b1;
            n_count = '0;
            n_ovf   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc   <= ESC_IDLE;
            r_high  <= '0;
            r_name  <= 1'b1;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_accept) begin
            r_esc   <= n_esc;
            r_high  <= n_high;
            r_name  <= n_name;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    assign o_push              = i_accept & (i_query_end | have | pend);
    assign o_result.data_valid = have;
    assign o_result.out_byte   = have ? ch : '0;
    assign o_result.in_name    = have & r_name;
    assign o_result.pair_end   = i_query_end | pend;
    assign o_result.query_done = i_query_end;
    assign o_result.too_long   = i_query_end & ovf;

    a_blank_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && !o_result.data_valid |-> o_result.out_byte == '0 && !o_result.in_name)
        else $error("fields not cleared without data");

    a_done_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_result.query_done |-> o_result.pair_end)
        else $error("query end without pair end");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_query_end |=> r_count == '0 && !r_ovf && r_esc == ESC_IDLE)
        else $error("query state not cleared at query end");

endmodule

### rtl/core/fqd_outbuf.sv
module fqd_outbuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  fqd_pkg::t_result  i_result,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_stall,
    output fqd_pkg::t_result  o_result
);
    import fqd_pkg::*;

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    take;

    assign take = r_out_valid & ~i_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (take) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || take) begin
                n_out       = i_result;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = i_result;
                n_skid_valid = 1'b1;
            end
        end else if (take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_full   = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry without output entry");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_push)
        else $error("transaction pushed into full buffer");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && take |=> r_out_valid && !r_skid_valid && r_out == $past(r_skid))
        else $error("skid entry lost");

endmodule

### rtl/core/form_query_decoder.sv
// A result is registered in the output register, or in the skid entry if held.
// Throughput: one byte per cycle; the input stalls only while the two-entry
// output buffer is full, i.e. from the cycle after a waiting result was stalled
// while another result arrived, until the output takes one.
// Reset (synchronous, active low): max_length returns to 900, the escape,
// byte count and overflow state clear, the name flag sets, and the output buffer empties.
module form_query_decoder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fqd_pkg::AddrW-1:0]   paddr,
    input  logic [fqd_pkg::DataW-1:0]   pwdata,
    output logic [fqd_pkg::DataW-1:0]   prdata,
    output logic                        pready,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [fqd_pkg::ByteW-1:0]   i_in_byte,
    input  logic                        i_query_end,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_data_valid,
    output logic [fqd_pkg::ByteW-1:0]   o_out_byte,
    output logic                        o_in_name,
    output logic                        o_pair_end,
    output logic                        o_query_done,
    output logic                        o_too_long
);
    import fqd_pkg::*;

    logic [CountW-1:0] max_length;
    logic              accept;
    logic              push;
    logic              full;
    t_result           step_result;
    t_result           out_result;

    fqd_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_max_length (max_length)
    );

    assign o_stall = full;
    assign accept  = i_valid & ~full;

    fqd_step u_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_in_byte    (i_in_byte),
        .i_query_end  (i_query_end),
        .i_max_length (max_length),
        .o_push       (push),
        .o_result     (step_result)
    );

    fqd_outbuf u_outbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (step_result),
        .o_full   (full),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (out_result)
    );

    assign o_data_valid = out_result.data_valid;
    assign o_out_byte   = out_result.out_byte;
    assign o_in_name    = out_result.in_name;
    assign o_pair_end   = out_result.pair_end;
    assign o_query_done = out_result.query_done;
    assign o_too_long   = out_result.too_long;

endmodule
